// ===== design/aesp_pkg.sv =====
// ----------------------------------------------------------------------------
// ANSI escape parser package
// Character codes, result kinds, SGR codes and the command table shared by the
// parser modules.
// ----------------------------------------------------------------------------
`default_nettype none

package aesp_pkg;

  localparam int MAX_PARAMS_DEF  = 16;
  localparam int NUMBER_BITS_DEF = 16;

  localparam logic [7:0] CHR_NUL    = 8'd0;
  localparam logic [7:0] CHR_ESC    = 8'd27;
  localparam logic [7:0] CHR_LBRACK = 8'h5b;
  localparam logic [7:0] CHR_QUEST  = 8'h3f;
  localparam logic [7:0] CHR_EQUAL  = 8'h3d;
  localparam logic [7:0] CHR_SEMI   = 8'h3b;
  localparam logic [7:0] CHR_SPACE  = 8'h20;
  localparam logic [7:0] CHR_TAB    = 8'h09;
  localparam logic [7:0] CHR_CR     = 8'h0d;
  localparam logic [7:0] CHR_ZERO   = 8'h30;
  localparam logic [7:0] CHR_NINE   = 8'h39;
  localparam logic [7:0] CHR_SGR    = 8'h6d;

  localparam logic [1:0] KIND_TEXT   = 2'd0;
  localparam logic [1:0] KIND_ACCEPT = 2'd1;
  localparam logic [1:0] KIND_REJECT = 2'd2;

  localparam logic [7:0] ATTR_RESET  = 8'h0f;
  localparam logic [7:0] ATTR_FG_BRT = 8'h08;
  localparam logic [7:0] ATTR_BG_BRT = 8'h80;
  localparam logic [7:0] ATTR_FG_KEEP = 8'hf8;
  localparam logic [7:0] ATTR_BG_KEEP = 8'h8f;

  localparam int SGR_RESET   = 0;
  localparam int SGR_BOLD    = 1;
  localparam int SGR_FAINT   = 2;
  localparam int SGR_BG_BRT  = 3;
  localparam int SGR_BG_NORM = 6;
  localparam int SGR_FG_LO   = 30;
  localparam int SGR_FG_HI   = 37;
  localparam int SGR_BG_LO   = 40;
  localparam int SGR_BG_HI   = 47;

  function automatic logic is_space(input logic [7:0] c);
    return (c == CHR_SPACE) || ((c >= CHR_TAB) && (c <= CHR_CR));
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= CHR_ZERO) && (c <= CHR_NINE);
  endfunction

  function automatic logic [2:0] swap02(input logic [2:0] v);
    return {v[0], v[1], v[2]};
  endfunction

  // Command table: known final bytes and their parameter count limits.
  function automatic logic cmd_ok(input logic [7:0] c, input int unsigned cnt);
    int unsigned lo;
    int unsigned hi;
    logic        known;
    logic        unlimited;
    lo        = 0;
    hi        = 0;
    known     = 1'b1;
    unlimited = 1'b0;
    case (c)
      "A", "B", "C", "D", "E", "F", "G", "J", "K", "S", "T": begin
        hi = 1;
      end
      "H", "f": begin
        hi = 2;
      end
      "m": begin
        lo        = 1;
        unlimited = 1'b1;
      end
      "s", "u": begin
        hi = 0;
      end
      "l", "h": begin
        lo = 1;
        hi = 1;
      end
      default: begin
        known = 1'b0;
      end
    endcase
    return known && (cnt >= lo) && (unlimited || (cnt <= hi));
  endfunction

endpackage

`default_nettype wire

// ===== design/aesp_ram.sv =====
// ----------------------------------------------------------------------------
// Generic single-port-write RAM
// One write port and one read port with a registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module aesp_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ===== design/aesp_sgr_unit.sv =====
// ----------------------------------------------------------------------------
// SGR attribute unit
// Applies one select-graphic-rendition parameter to the colour attribute.
// ----------------------------------------------------------------------------
`default_nettype none

module aesp_sgr_unit
  import aesp_pkg::*;
#(
  parameter int NUMBER_BITS = NUMBER_BITS_DEF
) (
  input  wire logic [7:0]             attr_in,
  input  wire logic [NUMBER_BITS-1:0] param,
  output logic      [7:0]             attr_out
);

  logic [NUMBER_BITS-1:0] fg_off;
  logic [NUMBER_BITS-1:0] bg_off;

  assign fg_off = param - NUMBER_BITS'(SGR_FG_LO);
  assign bg_off = param - NUMBER_BITS'(SGR_BG_LO);

  always_comb begin
    attr_out = attr_in;
    if (param == NUMBER_BITS'(SGR_RESET)) begin
      attr_out = ATTR_RESET;
    end else if (param == NUMBER_BITS'(SGR_BOLD)) begin
      attr_out = attr_in | ATTR_FG_BRT;
    end else if (param == NUMBER_BITS'(SGR_FAINT)) begin
      attr_out = attr_in & ~ATTR_FG_BRT;
    end else if (param == NUMBER_BITS'(SGR_BG_BRT)) begin
      attr_out = attr_in | ATTR_BG_BRT;
    end else if (param == NUMBER_BITS'(SGR_BG_NORM)) begin
      attr_out = attr_in & ~ATTR_BG_BRT;
    end else if ((param >= NUMBER_BITS'(SGR_FG_LO)) && (param <= NUMBER_BITS'(SGR_FG_HI))) begin
      attr_out = (attr_in & ATTR_FG_KEEP) | {5'b0, swap02(fg_off[2:0])};
    end else if ((param >= NUMBER_BITS'(SGR_BG_LO)) && (param <= NUMBER_BITS'(SGR_BG_HI))) begin
      attr_out = (attr_in & ATTR_BG_KEEP) | {1'b0, swap02(bg_off[2:0]), 4'b0};
    end
  end

endmodule

`default_nettype wire

// ===== design/ansi_escape_sequence_parser.sv =====
// ----------------------------------------------------------------------------
// ANSI CSI escape sequence parser
// Results are registered. Throughput: one character per cycle while the
// output is free, except an accepted 'm' command, which holds the input
// while it walks its N stored parameters through the store's read port
// and the shared SGR unit.
// Reset (synchronous, active low) clears the parser and sets the attribute to 0x0f.
// ----------------------------------------------------------------------------
`default_nettype none

module ansi_escape_sequence_parser
  import aesp_pkg::*;
#(
  parameter int MAX_PARAMS  = MAX_PARAMS_DEF,
  parameter int NUMBER_BITS = NUMBER_BITS_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [7:0]  in_char_in,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [1:0]       out_kind,
  output logic [7:0]       out_byte_out,
  output logic [7:0]       out_attribute,
  output logic [4:0]       out_param_count,
  output logic [15:0]      out_first_param,
  output logic [15:0]      out_second_param
);

  localparam int CNT_W = $clog2(MAX_PARAMS + 1);
  localparam int IDX_W = $clog2(MAX_PARAMS);
  localparam int NW    = NUMBER_BITS;

  localparam logic [2:0] ST_BEGIN  = 3'd0;
  localparam logic [2:0] ST_ESC1   = 3'd1;
  localparam logic [2:0] ST_ESC2   = 3'd2;
  localparam logic [2:0] ST_ESC3   = 3'd3;
  localparam logic [2:0] ST_TEXT   = 3'd4;
  localparam logic [2:0] ST_DIGITS = 3'd5;
  localparam logic [2:0] ST_POST   = 3'd6;
  localparam logic [2:0] ST_WALK   = 3'd7;

  localparam logic [NW-1:0] NUM_MAX = {NW{1'b1}};

  logic [2:0]       state_r, state_nxt;
  logic [NW-1:0]    accum_r, accum_nxt;
  logic [CNT_W-1:0] total_r, total_nxt;
  logic [NW-1:0]    p0_r, p0_nxt;
  logic [NW-1:0]    p1_r, p1_nxt;
  logic [7:0]       attr_r, attr_nxt;
  logic [CNT_W-1:0] walk_idx_r, walk_idx_nxt;
  logic             rd_pend_r, rd_pend_nxt;

  logic             out_valid_r, out_valid_nxt;
  logic [1:0]       out_kind_r, out_kind_nxt;
  logic [7:0]       out_byte_r, out_byte_nxt;
  logic [7:0]       out_attr_r, out_attr_nxt;
  logic [4:0]       out_cnt_r, out_cnt_nxt;
  logic [15:0]      out_p0_r, out_p0_nxt;
  logic [15:0]      out_p1_r, out_p1_nxt;

  logic             acc;
  logic             out_free;
  logic [7:0]       c;
  logic             c_sp;
  logic             c_dg;
  logic             c_semi;
  logic [NW+3:0]    acc_ext;
  logic [NW+3:0]    acc_sum;
  logic [NW-1:0]    acc_sat;
  logic             add_now;
  logic             store_now;
  logic [CNT_W-1:0] eff_total;
  logic [NW-1:0]    eff_p0;
  logic [NW-1:0]    eff_p1;
  logic             cmd_good;
  logic             issue;
  logic             walk_done;
  logic [NW-1:0]    rd_data;
  logic [7:0]       sgr_attr;
  logic [NW+15:0]   p0_wide;
  logic [NW+15:0]   p1_wide;
  logic [CNT_W+4:0] cnt_wide;

  assign c        = in_char_in;
  assign out_free = !out_valid_r || out_ready;
  assign in_ready = (state_r != ST_WALK) && out_free;
  assign acc      = in_valid && in_ready;
  assign c_sp     = is_space(c);
  assign c_dg     = is_digit(c);
  assign c_semi   = (c == CHR_SEMI);

  assign acc_ext = {4'b0, accum_r};
  assign acc_sum = (acc_ext << 3) + (acc_ext << 1) + {{NW{1'b0}}, c[3:0]};
  assign acc_sat = (acc_sum > {4'b0, NUM_MAX}) ? NUM_MAX : acc_sum[NW-1:0];

  assign add_now   = (state_r == ST_DIGITS) && !c_dg;
  assign store_now = add_now && (total_r < CNT_W'(MAX_PARAMS));
  assign eff_total = store_now ? total_r + CNT_W'(1) : total_r;
  assign eff_p0    = (store_now && (total_r == CNT_W'(0))) ? accum_r : p0_r;
  assign eff_p1    = (store_now && (total_r == CNT_W'(1))) ? accum_r : p1_r;
  assign cmd_good  = cmd_ok(c, 32'(eff_total));

  assign issue     = (state_r == ST_WALK) && (walk_idx_r < total_r);
  assign walk_done = (state_r == ST_WALK) && !issue && !rd_pend_r && out_free;

  assign p0_wide  = {16'b0, (total_r > CNT_W'(0)) ? p0_r : {NW{1'b0}}};
  assign p1_wide  = {16'b0, (total_r > CNT_W'(1)) ? p1_r : {NW{1'b0}}};
  assign cnt_wide = {5'b0, total_r};

  aesp_ram #(
    .WIDTH (NW),
    .DEPTH (MAX_PARAMS)
  ) u_store (
    .clk   (clk),
    .we    (acc && store_now),
    .waddr (total_r[IDX_W-1:0]),
    .wdata (accum_r),
    .raddr (walk_idx_r[IDX_W-1:0]),
    .rdata (rd_data)
  );

  aesp_sgr_unit #(
    .NUMBER_BITS (NW)
  ) u_sgr (
    .attr_in  (attr_r),
    .param    (rd_data),
    .attr_out (sgr_attr)
  );

  always_comb begin
    logic [NW+15:0]   e0;
    logic [NW+15:0]   e1;
    logic [CNT_W+4:0] ec;
    logic             do_final;
    e0            = {16'b0, (eff_total > CNT_W'(0)) ? eff_p0 : {NW{1'b0}}};
    e1            = {16'b0, (eff_total > CNT_W'(1)) ? eff_p1 : {NW{1'b0}}};
    ec            = {5'b0, eff_total};
    do_final      = 1'b0;
    state_nxt     = state_r;
    accum_nxt     = accum_r;
    total_nxt     = total_r;
    p0_nxt        = p0_r;
    p1_nxt        = p1_r;
    attr_nxt      = attr_r;
    walk_idx_nxt  = walk_idx_r;
    rd_pend_nxt   = 1'b0;
    out_valid_nxt = out_valid_r && !out_ready;
    out_kind_nxt  = out_kind_r;
    out_byte_nxt  = out_byte_r;
    out_attr_nxt  = out_attr_r;
    out_cnt_nxt   = out_cnt_r;
    out_p0_nxt    = out_p0_r;
    out_p1_nxt    = out_p1_r;

    if (state_r == ST_WALK) begin
      rd_pend_nxt = issue;
      if (issue) begin
        walk_idx_nxt = walk_idx_r + CNT_W'(1);
      end
      if (rd_pend_r) begin
        attr_nxt = sgr_attr;
      end
      if (walk_done) begin
        out_valid_nxt = 1'b1;
        out_kind_nxt  = KIND_ACCEPT;
        out_byte_nxt  = CHR_SGR;
        out_attr_nxt  = attr_r;
        out_cnt_nxt   = cnt_wide[4:0];
        out_p0_nxt    = p0_wide[15:0];
        out_p1_nxt    = p1_wide[15:0];
        total_nxt     = '0;
        accum_nxt     = '0;
        p0_nxt        = '0;
        p1_nxt        = '0;
        state_nxt     = ST_BEGIN;
      end
    end else if (acc) begin
      if (c == CHR_NUL) begin
        state_nxt = ST_BEGIN;
        accum_nxt = '0;
        total_nxt = '0;
        p0_nxt    = '0;
        p1_nxt    = '0;
        attr_nxt  = ATTR_RESET;
      end else begin
        case (state_r)
          ST_BEGIN, ST_TEXT: begin
            if (c == CHR_ESC) begin
              state_nxt = ST_ESC1;
            end else begin
              state_nxt     = ST_TEXT;
              out_valid_nxt = 1'b1;
              out_kind_nxt  = KIND_TEXT;
              out_byte_nxt  = c;
              out_attr_nxt  = attr_r;
              out_cnt_nxt   = '0;
              out_p0_nxt    = '0;
              out_p1_nxt    = '0;
            end
          end
          ST_ESC1: begin
            state_nxt = (c == CHR_LBRACK) ? ST_ESC2 : ST_BEGIN;
          end
          ST_ESC2, ST_ESC3: begin
            if ((state_r == ST_ESC2) && ((c == CHR_QUEST) || (c == CHR_EQUAL))) begin
              state_nxt = ST_ESC3;
            end else if (c_sp || c_semi) begin
              state_nxt = state_r;
            end else if (c_dg) begin
              accum_nxt = {{(NW-4){1'b0}}, c[3:0]};
              state_nxt = ST_DIGITS;
            end else begin
              total_nxt = '0;
              accum_nxt = '0;
              p0_nxt    = '0;
              p1_nxt    = '0;
              state_nxt = ST_BEGIN;
            end
          end
          ST_DIGITS: begin
            if (c_dg) begin
              accum_nxt = acc_sat;
            end else begin
              total_nxt = eff_total;
              p0_nxt    = eff_p0;
              p1_nxt    = eff_p1;
              if (c_sp) begin
                state_nxt = ST_POST;
              end else if (c_semi) begin
                state_nxt = ST_ESC2;
              end else begin
                do_final = 1'b1;
              end
            end
          end
          ST_POST: begin
            if (c_semi) begin
              state_nxt = ST_ESC2;
            end else if (!c_sp) begin
              do_final = 1'b1;
            end
          end
          default: begin
            state_nxt = ST_BEGIN;
          end
        endcase
        if (do_final) begin
          if (cmd_good && (c == CHR_SGR)) begin
            state_nxt    = ST_WALK;
            walk_idx_nxt = '0;
          end else begin
            out_valid_nxt = 1'b1;
            out_kind_nxt  = cmd_good ? KIND_ACCEPT : KIND_REJECT;
            out_byte_nxt  = c;
            out_attr_nxt  = attr_r;
            out_cnt_nxt   = ec[4:0];
            out_p0_nxt    = e0[15:0];
            out_p1_nxt    = e1[15:0];
            total_nxt     = '0;
            accum_nxt     = '0;
            p0_nxt        = '0;
            p1_nxt        = '0;
            state_nxt     = ST_BEGIN;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_BEGIN;
      accum_r     <= '0;
      total_r     <= '0;
      p0_r        <= '0;
      p1_r        <= '0;
      attr_r      <= ATTR_RESET;
      walk_idx_r  <= '0;
      rd_pend_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      accum_r     <= accum_nxt;
      total_r     <= total_nxt;
      p0_r        <= p0_nxt;
      p1_r        <= p1_nxt;
      attr_r      <= attr_nxt;
      walk_idx_r  <= walk_idx_nxt;
      rd_pend_r   <= rd_pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_kind_r <= out_kind_nxt;
    out_byte_r <= out_byte_nxt;
    out_attr_r <= out_attr_nxt;
    out_cnt_r  <= out_cnt_nxt;
    out_p0_r   <= out_p0_nxt;
    out_p1_r   <= out_p1_nxt;
  end

  assign out_valid        = out_valid_r;
  assign out_kind         = out_kind_r;
  assign out_byte_out     = out_byte_r;
  assign out_attribute    = out_attr_r;
  assign out_param_count  = out_cnt_r;
  assign out_first_param  = out_p0_r;
  assign out_second_param = out_p1_r;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (total_r <= CNT_W'(MAX_PARAMS)) && ((state_r != ST_WALK) || (walk_idx_r <= total_r)))
    else $error("parameter count or walk index out of range");

  a_walk_result: assert property (@(posedge clk) disable iff (!rst_n)
    walk_done |=> out_valid_r && (out_kind_r == KIND_ACCEPT) && (out_byte_r == CHR_SGR))
    else $error("parameter walk ended without an accepted result");

  a_walk_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != ST_WALK) ##1 (state_r == ST_WALK) |-> (total_r != CNT_W'(0)))
    else $error("parameter walk started with no parameters");

  a_text_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (out_kind_r == KIND_TEXT) |->
      (out_cnt_r == 5'd0) && (out_p0_r == 16'd0) && (out_p1_r == 16'd0))
    else $error("text result carries parameters");

  a_nul_reset: assert property (@(posedge clk) disable iff (!rst_n)
    acc && (c == CHR_NUL) |=> (attr_r == ATTR_RESET) && (total_r == CNT_W'(0)))
    else $error("string end did not reset the parser");

endmodule

`default_nettype wire
